[rtl/servo_bus_status_packet_parser_macros.svh]
// assertion macros used by the checker
`ifndef SERVO_BUS_STATUS_PACKET_PARSER_MACROS_SVH
`define SERVO_BUS_STATUS_PACKET_PARSER_MACROS_SVH

// same-cycle implication, off while dis is high
`define SBSP_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("sbsp check failed");

// next-cycle implication, off while dis is high
`define SBSP_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("sbsp check failed");

`endif

[rtl/sbsp_pkg.sv]
package sbsp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // input item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] RES_PARAM   = 2'd0;
  localparam logic [1:0] RES_DONE    = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd0;
  localparam logic [1:0] REG_BUFFER_LIMIT   = 2'd1;
  localparam logic [1:0] REG_CAPTURE_PARAMS = 2'd2;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [7:0] servo_id;
    logic [7:0] error_code;
    logic [7:0] param_count;
    logic       checksum_ok;
    logic       overrun;
    logic       frame_good;
  } result_t;

endpackage

[rtl/servo_bus_status_packet_parser.sv]
// channel   direction  handshake                     payload
// in        to block   in_valid / in_stall           kind, rx_byte
// out       from block out_valid / out_stall         result_kind .. frame_good
// cfg       to block   cfg_valid / cfg_ready         cfg_index, cfg_data
//
// one item is taken per cycle while in_stall is low; its state update and
// result are formed in the same cycle and the result is registered. a skid
// register behind the output register absorbs one result while out_stall is
// high; in_stall rises only when that skid register is full.
// rst is synchronous: parser disarmed, registers back to their reset values.
module servo_bus_status_packet_parser
  import sbsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] param_byte,
  output logic [7:0] param_index,
  output logic [7:0] servo_id,
  output logic [7:0] error_code,
  output logic [7:0] param_count,
  output logic       checksum_ok,
  output logic       overrun,
  output logic       frame_good,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_ID, PH_LEN, PH_ERR, PH_DATA, PH_CSUM
  } phase_t;

  logic [7:0] timeout_ticks;
  logic [7:0] buffer_limit;
  logic       capture_params;

  phase_t     phase, phase_next;
  logic       armed, armed_next;
  logic [7:0] budget, budget_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_error, held_error_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] param_pos, param_pos_next;
  logic [7:0] running_sum, running_sum_next;
  logic       overrun_flag, overrun_flag_next;

  result_t    res;
  logic       res_valid;
  result_t    out_data, skid_data;
  logic       skid_valid;

  logic       accept;
  logic       pop;
  logic [7:0] sum_add;
  logic [7:0] pos_inc;
  logic       csum_match;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  assign sum_add    = running_sum + rx_byte;
  assign pos_inc    = param_pos + 8'd1;
  assign csum_match = (~running_sum) == rx_byte;

  always_comb begin
    phase_next        = phase;
    armed_next        = armed;
    budget_next       = budget;
    held_id_next      = held_id;
    held_error_next   = held_error;
    held_length_next  = held_length;
    param_pos_next    = param_pos;
    running_sum_next  = running_sum;
    overrun_flag_next = overrun_flag;
    res               = '0;
    res_valid         = 1'b0;
    if (accept) begin
      case (kind)
        KIND_START: begin
          phase_next        = PH_SYNC1;
          held_id_next      = '0;
          held_error_next   = '0;
          held_length_next  = '0;
          param_pos_next    = '0;
          running_sum_next  = '0;
          overrun_flag_next = 1'b0;
          budget_next       = timeout_ticks;
          if (timeout_ticks == 8'd0) begin
            armed_next      = 1'b0;
            res.result_kind = RES_TIMEOUT;
            res_valid       = 1'b1;
          end else begin
            armed_next = 1'b1;
          end
        end
        KIND_TICK: begin
          if (armed) begin
            budget_next = budget - 8'd1;
            if (budget == 8'd1) begin
              armed_next      = 1'b0;
              res.result_kind = RES_TIMEOUT;
              res_valid       = 1'b1;
            end
          end
        end
        KIND_BYTE: begin
          if (armed) begin
            unique case (phase)
              PH_SYNC1: begin
                if (rx_byte == SYNC_BYTE) phase_next = PH_SYNC2;
              end
              PH_SYNC2: begin
                phase_next = (rx_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
              end
              PH_ID: begin
                held_id_next     = rx_byte;
                running_sum_next = sum_add;
                phase_next       = PH_LEN;
              end
              PH_LEN: begin
                held_length_next = rx_byte;
                running_sum_next = sum_add;
                phase_next       = (rx_byte == 8'd0) ? PH_CSUM : PH_ERR;
              end
              PH_ERR: begin
                held_error_next  = rx_byte;
                running_sum_next = sum_add;
                phase_next       = (held_length <= 8'd2) ? PH_CSUM : PH_DATA;
              end
              PH_DATA: begin
                running_sum_next = sum_add;
                if (capture_params) begin
                  if (param_pos < buffer_limit) begin
                    res.result_kind = RES_PARAM;
                    res.param_byte  = rx_byte;
                    res.param_index = param_pos;
                    res_valid       = 1'b1;
                  end else begin
                    overrun_flag_next = 1'b1;
                  end
                end
                param_pos_next = pos_inc;
                if (pos_inc >= held_length - 8'd2) phase_next = PH_CSUM;
              end
              PH_CSUM: begin
                armed_next      = 1'b0;
                phase_next      = PH_SYNC1;
                res.result_kind = RES_DONE;
                res.servo_id    = held_id;
                res.error_code  = held_error;
                res.param_count = param_pos;
                res.checksum_ok = csum_match;
                res.overrun     = overrun_flag;
                res.frame_good  = csum_match && !overrun_flag;
                res_valid       = 1'b1;
              end
              default: phase_next = PH_SYNC1;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= 8'd1;
      buffer_limit   <= 8'd253;
      capture_params <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
        REG_BUFFER_LIMIT:   buffer_limit   <= cfg_data;
        REG_CAPTURE_PARAMS: capture_params <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      armed        <= 1'b0;
      budget       <= '0;
      held_id      <= '0;
      held_error   <= '0;
      held_length  <= '0;
      param_pos    <= '0;
      running_sum  <= '0;
      overrun_flag <= 1'b0;
    end else begin
      phase        <= phase_next;
      armed        <= armed_next;
      budget       <= budget_next;
      held_id      <= held_id_next;
      held_error   <= held_error_next;
      held_length  <= held_length_next;
      param_pos    <= param_pos_next;
      running_sum  <= running_sum_next;
      overrun_flag <= overrun_flag_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || pop) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign result_kind = out_data.result_kind;
  assign param_byte  = out_data.param_byte;
  assign param_index = out_data.param_index;
  assign servo_id    = out_data.servo_id;
  assign error_code  = out_data.error_code;
  assign param_count = out_data.param_count;
  assign checksum_ok = out_data.checksum_ok;
  assign overrun     = out_data.overrun;
  assign frame_good  = out_data.frame_good;

endmodule

[rtl/sbsp_checker.sv]
`include "servo_bus_status_packet_parser_macros.svh"

module sbsp_checker
  import sbsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] result_kind,
  input logic [7:0] param_byte,
  input logic [7:0] param_index,
  input logic [7:0] servo_id,
  input logic [7:0] error_code,
  input logic [7:0] param_count,
  input logic       checksum_ok,
  input logic       overrun,
  input logic       frame_good
);

  // the input only stalls when a result is already waiting at the output
  `SBSP_ASSERT_NOW(a_stall_needs_out, clk, rst, in_stall, out_valid)

  `SBSP_ASSERT_NOW(a_good_flag, clk, rst, out_valid && result_kind == RES_DONE,
    frame_good == (checksum_ok && !overrun))

  `SBSP_ASSERT_NOW(a_param_fields, clk, rst, out_valid && result_kind == RES_PARAM,
    servo_id == 8'd0 && error_code == 8'd0 && param_count == 8'd0 && !checksum_ok && !frame_good)

  `SBSP_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall,
    out_valid && $stable(result_kind) && $stable(param_byte) && $stable(param_index))

  `SBSP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid && !in_stall)

endmodule

bind servo_bus_status_packet_parser sbsp_checker u_sbsp_checker (.*);
